/* hw/rtl/sqrb_pkg.sv */
package sqrb_pkg;

  // Width of the bound, of each numerator and of each denominator
  localparam int unsigned FRAC_W = 8;

  // Default configuration of the block
  localparam int unsigned BOUND_MAX_DEF     = 255;
  localparam int unsigned RADICAND_BITS_DEF = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic start;      // capture the item, clear the root unit
    logic root_step;  // one digit of floor(sqrt p)
    logic square;     // a * a
    logic init;       // set up the denominator search
    logic step_a;     // advance the denominator, tentative numerator
    logic step_b;     // settle floor(sqrt(p*d*d))
    logic step_c;     // clamp and form cross products
    logic step_d;     // update the best fractions
    logic load_out;   // move the best fractions to the result register
  } sqrb_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic root_last;   // current root digit is the last one
    logic bound_zero;  // no fraction can exist
    logic last_den;    // current denominator equals the bound
  } sqrb_sts_t;

endpackage

/* hw/rtl/sqrb_ctrl.sv */
module sqrb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sqrb_pkg::sqrb_cmd_t cmd_o,
  input  sqrb_pkg::sqrb_sts_t sts_i
);
  import sqrb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROOT,
    ST_SQUARE,
    ST_INIT,
    ST_STEP_A,
    ST_STEP_B,
    ST_STEP_C,
    ST_STEP_D,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Decode commands and next state
  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_last) begin
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = sts_i.bound_zero ? ST_DONE : ST_STEP_A;
      end
      ST_STEP_A: begin
        cmd_o.step_a = 1'b1;
        state_d      = ST_STEP_B;
      end
      ST_STEP_B: begin
        cmd_o.step_b = 1'b1;
        state_d      = ST_STEP_C;
      end
      ST_STEP_C: begin
        cmd_o.step_c = 1'b1;
        state_d      = ST_STEP_D;
      end
      ST_STEP_D: begin
        cmd_o.step_d = 1'b1;
        state_d      = sts_i.last_den ? ST_DONE : ST_STEP_A;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A new result never overwrites one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> out_free)
    else $error("result register overwritten");

  // An accepted item starts the root unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_ROOT))
    else $error("accepted item did not start the search");

  // The search ends after the last denominator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP_D && sts_i.last_den) |=> (state_q == ST_DONE))
    else $error("search ran past the bound");
`endif

endmodule

/* hw/rtl/sqrb_dp.sv */
module sqrb_dp #(
  parameter int unsigned BOUND_MAX     = sqrb_pkg::BOUND_MAX_DEF,
  parameter int unsigned RADICAND_BITS = sqrb_pkg::RADICAND_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [RADICAND_BITS-1:0]    radicand_i,
  input  logic [sqrb_pkg::FRAC_W-1:0] bound_i,
  input  sqrb_pkg::sqrb_cmd_t         cmd_i,
  output sqrb_pkg::sqrb_sts_t         sts_o,
  output logic [sqrb_pkg::FRAC_W-1:0] below_num_o,
  output logic [sqrb_pkg::FRAC_W-1:0] below_den_o,
  output logic                        below_found_o,
  output logic [sqrb_pkg::FRAC_W-1:0] above_num_o,
  output logic [sqrb_pkg::FRAC_W-1:0] above_den_o,
  output logic                        above_found_o
);
  import sqrb_pkg::*;

  localparam int unsigned HALF = (RADICAND_BITS + 1) / 2;   // digits of the root
  localparam int unsigned RW   = 2 * HALF;                  // padded radicand
  localparam int unsigned REMW = HALF + 2;                  // root remainder
  localparam int unsigned CW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int unsigned XW   = HALF + FRAC_W;             // floor(sqrt(p*d*d))
  localparam int unsigned QW   = 2 * XW + 2;                // squares and p*d*d
  localparam int unsigned PW   = 2 * FRAC_W;                // cross products
  localparam logic [FRAC_W-1:0] BOUND_SAT =
      (BOUND_MAX >= (2 ** FRAC_W) - 1) ? {FRAC_W{1'b1}} : FRAC_W'(BOUND_MAX);

  // Captured item
  logic [RADICAND_BITS-1:0] p_q;
  logic [FRAC_W-1:0]        n_q;

  // Root unit
  logic [RW-1:0]   rad_q;
  logic [REMW-1:0] rem_q;
  logic [HALF-1:0] a_q;
  logic [CW-1:0]   cnt_q;
  logic [RW-1:0]   a2_q;

  // Search state
  logic [QW-1:0]     ca_q, cb_q, w_q, q_q, s_q, inc_q, t0_q;
  logic [XW-1:0]     x_q, y_q, ad_q;
  logic [FRAC_W-1:0] d_q;

  // Candidate stage
  logic              lok_q, uok_q;
  logic [FRAC_W-1:0] xc_q, uc_q;
  logic [PW-1:0]     pl1_q, pl2_q, pu1_q, pu2_q;

  // Best fractions
  logic [FRAC_W-1:0] bx_q, by_q, ux_q, uy_q;
  logic              bf_q, uf_q;

  // Result register
  logic [FRAC_W-1:0] ob_num_q, ob_den_q, oa_num_q, oa_den_q;
  logic              ob_fnd_q, oa_fnd_q;

  // Combinational terms
  logic [REMW+1:0]   rem_t, trial;
  logic              root_ge;
  logic [RW-1:0]     a_ext;
  logic [QW-1:0]     t1;
  logic              t1_fits;
  logic [FRAC_W-1:0] xc;
  logic [XW:0]       uw, uc_full;
  logic [FRAC_W-1:0] bound_sat;

  // Saturate the bound
  assign bound_sat = (bound_i > BOUND_SAT) ? BOUND_SAT : bound_i;

  // One digit of the root: bring down two radicand bits, try root*4+1
  assign rem_t   = {rem_q, rad_q[RW-1 -: 2]};
  assign trial   = (REMW + 2)'({a_q, 2'b01});
  assign root_ge = (rem_t >= trial);
  assign a_ext   = RW'(a_q);

  // Next floor root: take y+1 when its square still fits under p*d*d
  assign t1      = t0_q + QW'({y_q, 1'b1});
  assign t1_fits = (t1 <= s_q);

  // Clamp the lower numerator, form the upper one as the ceiling root
  always_comb begin
    xc      = (x_q > XW'(n_q)) ? n_q : x_q[FRAC_W-1:0];
    uw      = {1'b0, x_q} + (XW + 1)'(q_q != s_q);
    uc_full = (uw == '0) ? (XW + 1)'(1) : uw;
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      p_q   <= radicand_i;
      n_q   <= bound_sat;
      rad_q <= RW'(radicand_i);
      rem_q <= '0;
      a_q   <= '0;
    end
    if (cmd_i.root_step) begin
      rad_q <= rad_q << 2;
      rem_q <= root_ge ? REMW'(rem_t - trial) : REMW'(rem_t);
      a_q   <= HALF'({a_q, root_ge});
    end
    if (cmd_i.square) begin
      a2_q <= a_ext * a_ext;
    end
    if (cmd_i.init) begin
      ca_q  <= QW'({a2_q, 1'b0});
      cb_q  <= QW'({a2_q, 1'b0}) + QW'({a_q, 1'b0});
      w_q   <= QW'(a2_q);
      q_q   <= '0;
      s_q   <= '0;
      inc_q <= QW'(p_q);
      x_q   <= '0;
      ad_q  <= '0;
      d_q   <= '0;
      bx_q  <= '0;
      by_q  <= '0;
      ux_q  <= '0;
      uy_q  <= '0;
    end
    if (cmd_i.step_a) begin
      d_q   <= d_q + FRAC_W'(1);
      ad_q  <= ad_q + XW'(a_q);
      s_q   <= s_q + inc_q;
      inc_q <= inc_q + QW'({p_q, 1'b0});
      t0_q  <= q_q + w_q;
      y_q   <= x_q + XW'(a_q);
    end
    if (cmd_i.step_b) begin
      if (t1_fits) begin
        x_q <= y_q + XW'(1);
        q_q <= t1;
        w_q <= w_q + cb_q;
      end else begin
        x_q <= y_q;
        q_q <= t0_q;
        w_q <= w_q + ca_q;
      end
    end
    if (cmd_i.step_c) begin
      lok_q <= (xc != '0) && (XW'(xc) >= ad_q);
      uok_q <= (uc_full <= (XW + 1)'(n_q)) &&
               (uc_full <= ({1'b0, ad_q} + (XW + 1)'(d_q)));
      xc_q  <= xc;
      uc_q  <= uc_full[FRAC_W-1:0];
      pl1_q <= PW'(xc) * PW'(by_q);
      pl2_q <= PW'(bx_q) * PW'(d_q);
      pu1_q <= PW'(uc_full[FRAC_W-1:0]) * PW'(uy_q);
      pu2_q <= PW'(ux_q) * PW'(d_q);
    end
    if (cmd_i.step_d) begin
      if (lok_q && (!bf_q || (pl1_q > pl2_q))) begin
        bx_q <= xc_q;
        by_q <= d_q;
      end
      if (uok_q && (!uf_q || (pu1_q < pu2_q))) begin
        ux_q <= uc_q;
        uy_q <= d_q;
      end
    end
    if (cmd_i.load_out) begin
      ob_num_q <= bx_q;
      ob_den_q <= by_q;
      ob_fnd_q <= bf_q;
      oa_num_q <= ux_q;
      oa_den_q <= uy_q;
      oa_fnd_q <= uf_q;
    end
  end

  // Digit counter and found flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      bf_q  <= 1'b0;
      uf_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.root_step) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.init) begin
        bf_q <= 1'b0;
        uf_q <= 1'b0;
      end else if (cmd_i.step_d) begin
        if (lok_q) begin
          bf_q <= 1'b1;
        end
        if (uok_q) begin
          uf_q <= 1'b1;
        end
      end
    end
  end

  assign sts_o.root_last  = (cnt_q == CW'(HALF - 1));
  assign sts_o.bound_zero = (n_q == '0);
  assign sts_o.last_den   = (d_q == n_q);

  assign below_num_o   = ob_num_q;
  assign below_den_o   = ob_den_q;
  assign below_found_o = ob_fnd_q;
  assign above_num_o   = oa_num_q;
  assign above_den_o   = oa_den_q;
  assign above_found_o = oa_fnd_q;

`ifndef NO_ASSERTIONS
  // The tracked numerator stays a floor root: its square never exceeds p*d*d
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_b |=> (q_q <= s_q))
    else $error("tracked square exceeds p*d*d");

  // The denominator never advances past the bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_a |-> (d_q < n_q))
    else $error("denominator advanced past the bound");

  // A found lower fraction has nonzero numerator and denominator
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bf_q |-> ((bx_q != '0) && (by_q != '0)))
    else $error("lower fraction found with a zero term");
`endif

endmodule

/* hw/rtl/sqrt_rational_bracket.sv */
// Channel | Handshake                  | Payload
// --------+----------------------------+------------------------------------------
// in      | in_valid_i / in_ready_o    | radicand_i, bound_i
// out     | out_valid_o / out_ready_i  | below_num_o, below_den_o, below_found_o,
//         |                            | above_num_o, above_den_o, above_found_o
//
// From accept to result an item computes one root digit per cycle, squares the root,
// then sets up the search and takes each denominator up to n, the saturated bound,
// in four steps (advance, settle the floor root, cross-multiply, compare).
// One item is worked at a time; in_ready_o is high only while the search is idle.
// A finished result waits in the output register, so the next item is taken
// while out_ready_i stalls; the search stalls only if a second result is ready.
// Reset clears the controller and the output valid flag.
module sqrt_rational_bracket #(
  parameter int unsigned BOUND_MAX     = sqrb_pkg::BOUND_MAX_DEF,
  parameter int unsigned RADICAND_BITS = sqrb_pkg::RADICAND_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [RADICAND_BITS-1:0]    radicand_i,
  input  logic [sqrb_pkg::FRAC_W-1:0] bound_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sqrb_pkg::FRAC_W-1:0] below_num_o,
  output logic [sqrb_pkg::FRAC_W-1:0] below_den_o,
  output logic                        below_found_o,
  output logic [sqrb_pkg::FRAC_W-1:0] above_num_o,
  output logic [sqrb_pkg::FRAC_W-1:0] above_den_o,
  output logic                        above_found_o
);
  import sqrb_pkg::*;

  sqrb_cmd_t cmd;
  sqrb_sts_t sts;

  // Sequence the search
  sqrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Root unit, denominator search and result register
  sqrb_dp #(
    .BOUND_MAX     (BOUND_MAX),
    .RADICAND_BITS (RADICAND_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .radicand_i    (radicand_i),
    .bound_i       (bound_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .below_num_o   (below_num_o),
    .below_den_o   (below_den_o),
    .below_found_o (below_found_o),
    .above_num_o   (above_num_o),
    .above_den_o   (above_den_o),
    .above_found_o (above_found_o)
  );

endmodule

/* tb/sv/tb_sqrt_rational_bracket.sv */
module tb_sqrt_rational_bracket;

  localparam int unsigned RAD_W       = sqrb_pkg::RADICAND_BITS_DEF;
  localparam int unsigned FW          = sqrb_pkg::FRAC_W;
  localparam int unsigned BOUND_LIMIT = sqrb_pkg::BOUND_MAX_DEF;
  localparam int unsigned RAND_ITEMS  = 557;
  localparam int unsigned DRAIN_AT    = 300;
  localparam int unsigned HOLD_AFTER  = 100;
  localparam int unsigned HOLD_CYCLES = 4000;
  localparam int unsigned CALM_LEVEL  = 40;
  localparam int unsigned TAIL_CYCLES = 1100;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  typedef struct {
    logic [RAD_W-1:0] radicand;
    logic [FW-1:0]    bound;
    bit               drain_first;
  } probe_t;

  typedef struct packed {
    logic [FW-1:0] below_num;
    logic [FW-1:0] below_den;
    logic          below_found;
    logic [FW-1:0] above_num;
    logic [FW-1:0] above_den;
    logic          above_found;
  } bracket_t;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             in_valid   = 1'b0;
  logic             in_ready_o;
  logic [RAD_W-1:0] radicand   = '0;
  logic [FW-1:0]    bound      = '0;
  logic             out_valid_o;
  logic             out_ready  = 1'b0;
  logic [FW-1:0]    below_num_o;
  logic [FW-1:0]    below_den_o;
  logic             below_found_o;
  logic [FW-1:0]    above_num_o;
  logic [FW-1:0]    above_den_o;
  logic             above_found_o;

  probe_t   probe_queue[$];
  bracket_t bracket_expected[$];
  bracket_t seen_res;
  bracket_t want_res;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  int unsigned hold_left    = 0;
  bit          hold_done    = 1'b0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;
  int unsigned cycle_cnt    = 0;

  sqrt_rational_bracket u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready_o),
    .radicand_i    (radicand),
    .bound_i       (bound),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready),
    .below_num_o   (below_num_o),
    .below_den_o   (below_den_o),
    .below_found_o (below_found_o),
    .above_num_o   (above_num_o),
    .above_den_o   (above_den_o),
    .above_found_o (above_found_o)
  );

  // Free-running clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Integer floor of the square root by binary search; m stays below 2^32
  function automatic longint unsigned floor_sqrt(longint unsigned m);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd1 << 17;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= m) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // Scan every denominator and keep the closest fractions on each side of the root
  function automatic bracket_t bracket_root(logic [RAD_W-1:0] p_in, logic [FW-1:0] n_in);
    longint unsigned p, n, a, d, sq, lo_x, hi_x;
    longint unsigned bx, by, ux, uy;
    bit bf, uf;
    bracket_t res;
    p  = p_in;
    n  = n_in;
    bx = 0; by = 0; ux = 0; uy = 0;
    bf = 1'b0; uf = 1'b0;
    if (n > BOUND_LIMIT) n = BOUND_LIMIT;
    a = floor_sqrt(p);
    for (d = 1; d <= n; d++) begin
      sq   = p * d * d;
      lo_x = floor_sqrt(sq);
      hi_x = (lo_x * lo_x < sq) ? lo_x + 1 : lo_x;
      if (lo_x > n) lo_x = n;
      if (lo_x >= 1 && lo_x >= a * d) begin
        if (!bf || lo_x * by > bx * d) begin
          bx = lo_x; by = d; bf = 1'b1;
        end
      end
      if (hi_x < 1) hi_x = 1;
      if (hi_x <= n && hi_x <= (a + 1) * d) begin
        if (!uf || hi_x * uy < ux * d) begin
          ux = hi_x; uy = d; uf = 1'b1;
        end
      end
    end
    res.below_num   = bx[FW-1:0];
    res.below_den   = by[FW-1:0];
    res.below_found = bf;
    res.above_num   = ux[FW-1:0];
    res.above_den   = uy[FW-1:0];
    res.above_found = uf;
    return res;
  endfunction

  function automatic probe_t make_probe(int unsigned p, int unsigned n, bit drain);
    probe_t pr;
    pr.radicand    = p[RAD_W-1:0];
    pr.bound       = n[FW-1:0];
    pr.drain_first = drain;
    return pr;
  endfunction

  // Driver: predict on accept, then present the next item or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready_o)
        bracket_expected.push_back(bracket_root(radicand, bound));
      if (!in_valid || in_ready_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (probe_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else if (probe_queue[0].drain_first && bracket_expected.size() != 0) begin
          in_valid <= 1'b0;
        end else if (probe_queue.size() >= CALM_LEVEL && $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 15);
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          radicand <= probe_queue[0].radicand;
          bound    <= probe_queue[0].bound;
          void'(probe_queue.pop_front());
        end
      end
    end
  end

  // Monitor: check each accepted result, then choose the next ready level
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      recv_gap  = 0;
      hold_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        seen_res.below_num   = below_num_o;
        seen_res.below_den   = below_den_o;
        seen_res.below_found = below_found_o;
        seen_res.above_num   = above_num_o;
        seen_res.above_den   = above_den_o;
        seen_res.above_found = above_found_o;
        if (bracket_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result with no item pending: below %0d/%0d f=%0d above %0d/%0d f=%0d",
                     seen_res.below_num, seen_res.below_den, seen_res.below_found,
                     seen_res.above_num, seen_res.above_den, seen_res.above_found);
        end else begin
          want_res = bracket_expected.pop_front();
          if (seen_res !== want_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR: result %0d: expected below %0d/%0d f=%0d above %0d/%0d f=%0d,",
                        " got below %0d/%0d f=%0d above %0d/%0d f=%0d"}, results_seen,
                       want_res.below_num, want_res.below_den, want_res.below_found,
                       want_res.above_num, want_res.above_den, want_res.above_found,
                       seen_res.below_num, seen_res.below_den, seen_res.below_found,
                       seen_res.above_num, seen_res.above_den, seen_res.above_found);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        // long hold-off so the block fills and stalls its input
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (probe_queue.size() >= CALM_LEVEL && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 15);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned i, kind, r, p, n;

    // Field extremes, zero bound, zero radicand, perfect squares and neighbors
    probe_queue.push_back(make_probe(0, 0, 1'b0));
    probe_queue.push_back(make_probe(0, 1, 1'b0));
    probe_queue.push_back(make_probe(0, 255, 1'b0));
    probe_queue.push_back(make_probe(1, 1, 1'b0));
    probe_queue.push_back(make_probe(1, 255, 1'b0));
    probe_queue.push_back(make_probe(65535, 255, 1'b0));
    probe_queue.push_back(make_probe(65535, 1, 1'b0));
    probe_queue.push_back(make_probe(65535, 0, 1'b0));
    probe_queue.push_back(make_probe(2, 255, 1'b0));
    probe_queue.push_back(make_probe(2, 1, 1'b0));
    probe_queue.push_back(make_probe(3, 1, 1'b0));
    probe_queue.push_back(make_probe(4, 10, 1'b0));
    probe_queue.push_back(make_probe(5, 2, 1'b0));
    probe_queue.push_back(make_probe(99, 7, 1'b0));
    probe_queue.push_back(make_probe(100, 255, 1'b0));
    probe_queue.push_back(make_probe(65025, 255, 1'b0));
    probe_queue.push_back(make_probe(65024, 255, 1'b0));
    probe_queue.push_back(make_probe(65026, 254, 1'b0));
    probe_queue.push_back(make_probe(16384, 128, 1'b0));
    probe_queue.push_back(make_probe(12345, 0, 1'b0));
    probe_queue.push_back(make_probe(16'hAAAA, 8'h55, 1'b0));
    probe_queue.push_back(make_probe(16'h5555, 8'hAA, 1'b0));
    probe_queue.push_back(make_probe(50000, 200, 1'b0));

    // Random part: mostly small bounds, a few large ones
    for (i = 0; i < RAND_ITEMS; i++) begin
      kind = $urandom_range(0, 9);
      case (kind)
        4, 5: begin
          r = $urandom_range(0, 255);
          p = r * r;
        end
        6: begin
          r = $urandom_range(1, 255);
          p = r * r + $urandom_range(0, 2) - 1;
        end
        7: p = $urandom_range(0, 30);
        8: p = 32'hFF00 | $urandom_range(0, 255);
        default: p = $urandom_range(0, 65535);
      endcase
      kind = $urandom_range(0, 19);
      if (kind == 0) n = ($urandom_range(0, 1) != 0) ? 255 : 0;
      else if (kind <= 2) n = $urandom_range(41, 255);
      else n = $urandom_range(1, 40);
      probe_queue.push_back(make_probe(p, n, i == DRAIN_AT));
    end

    // Reset
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain
    while (probe_queue.size() != 0 || in_valid || bracket_expected.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && bracket_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sqrb_pkg.sv
hw/rtl/sqrb_ctrl.sv
hw/rtl/sqrb_dp.sv
hw/rtl/sqrt_rational_bracket.sv
tb/sv/tb_sqrt_rational_bracket.sv
